// ----- design/dbs_pkg.sv -----
package dbs_pkg;

   // Sizes of the scheduler.
   localparam int NUM_BANKS   = 8;
   localparam int MAX_OPS     = 16;
   localparam int ROW_BITS    = 14;
   localparam int TAG_BITS    = 8;
   localparam int MAX_RESULTS = 8;
   localparam int CMDQ_DEPTH  = 2;
   localparam int RSPQ_DEPTH  = 4;

   localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int SLOT_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
   localparam int CNT_W  = $clog2(MAX_OPS + 1);
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);

   // Fixed field widths.
   localparam int SIZE_W = 9;
   localparam int TIME_W = 9;
   localparam int BW_W   = 7;
   localparam int TM_W   = 4;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Result kinds.
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_IDLE   = 2'd3;

   // Register indexes.
   localparam logic [2:0] CSR_CAS = 3'd0;
   localparam logic [2:0] CSR_RCD = 3'd1;
   localparam logic [2:0] CSR_RP  = 3'd2;
   localparam logic [2:0] CSR_BW  = 3'd3;

   // Classified input word.
   typedef struct packed {
      logic                is_tick;
      logic                is_write;
      logic [BANK_W-1:0]   bank;
      logic [ROW_BITS-1:0] row;
      logic [SIZE_W-1:0]   size;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   // Result word.
   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        tag;
      logic              is_write;
      logic              hit;
      logic [TIME_W-1:0] latency;
      logic              last;
   } rsp_type;

   // One operation slot.
   typedef struct packed {
      logic                accessing;
      logic                is_write;
      logic [BANK_W-1:0]   bank;
      logic [ROW_BITS-1:0] row;
      logic [SIZE_W-1:0]   size;
      logic [TAG_BITS-1:0] tag;
      logic [TIME_W-1:0]   cycles;
      logic [TIME_W-1:0]   access_time;
      logic                hit;
   } slot_type;

endpackage

// ----- design/dram_bank_open_page_scheduler.sv -----
// A request passes the input queue; its answer then passes the result queue.
// A tick loads and counts each occupied slot, runs the serial size-by-bandwidth
// divider for each operation it starts, and closes the pass; at most 16 slots.
// One word is in work at a time; one more can wait in the input queue.
// Reset (synchronous, active high) empties both queues and the slot queue,
// marks every bank free with its row unknown, and loads the timing defaults.
module dram_bank_open_page_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic        req_is_write,
   input  logic [2:0]  req_bank_index,
   input  logic [13:0] req_row_index,
   input  logic [8:0]  req_size_bytes,
   input  logic [7:0]  req_tag,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_done_tag,
   output logic        rsp_done_is_write,
   output logic        rsp_row_hit,
   output logic [8:0]  rsp_latency,
   output logic        rsp_last
);
   import dbs_pkg::*;

   logic    cmd_valid, cmd_pop, rsp_push, rsp_full;
   cmd_type cmd;
   rsp_type rsp_in, rsp_out;

   // Front: take and classify words.
   dbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_is_write   (req_is_write),
      .req_bank_index (req_bank_index),
      .req_row_index  (req_row_index),
      .req_size_bytes (req_size_bytes),
      .req_tag        (req_tag),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // Back: slot queue and bank timing.
   dbs_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_in),
      .rsp_full  (rsp_full)
   );

   // Result queue.
   dbs_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_word (rsp_in),
      .wr_full (rsp_full),
      .empty   (empty),
      .pop     (pop),
      .rd_word (rsp_out)
   );

   assign rsp_kind          = rsp_out.kind;
   assign rsp_done_tag      = rsp_out.tag;
   assign rsp_done_is_write = rsp_out.is_write;
   assign rsp_row_hit       = rsp_out.hit;
   assign rsp_latency       = rsp_out.latency;
   assign rsp_last          = rsp_out.last;

endmodule

// ----- design/dbs_front.sv -----
module dbs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_type,
   input  logic                         req_is_write,
   input  logic [2:0]                   req_bank_index,
   input  logic [13:0]                  req_row_index,
   input  logic [8:0]                   req_size_bytes,
   input  logic [7:0]                   req_tag,
   output logic                         cmd_valid,
   output dbs_pkg::cmd_type             cmd,
   input  logic                         cmd_pop
);
   import dbs_pkg::*;

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int QC_W  = $clog2(CMDQ_DEPTH + 1);

   cmd_type             mem_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]    wr_ff, rd_ff;
   logic [QC_W-1:0]     cnt_ff;
   cmd_type             word_in;
   logic                do_push, do_pop;

   // Classify the incoming word and fold the bank into range.
   always_comb begin
      word_in.is_tick  = req_type;
      word_in.is_write = req_is_write;
      word_in.bank     = BANK_W'(req_bank_index % NUM_BANKS);
      word_in.row      = ROW_BITS'(req_row_index);
      word_in.size     = req_size_bytes;
      word_in.tag      = TAG_BITS'(req_tag);
   end

   assign full      = (cnt_ff == QC_W'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // Short queue toward the scheduler.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ff] <= word_in;
            wr_ff <= (wr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_ff + QC_W'(do_push) - QC_W'(do_pop);
      end
   end

endmodule

// ----- design/dbs_rsp_queue.sv -----
module dbs_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  dbs_pkg::rsp_type wr_word,
   output logic             wr_full,
   output logic             empty,
   input  logic             pop,
   output dbs_pkg::rsp_type rd_word
);
   import dbs_pkg::*;

   localparam int PTR_W = (RSPQ_DEPTH > 1) ? $clog2(RSPQ_DEPTH) : 1;
   localparam int QC_W  = $clog2(RSPQ_DEPTH + 1);

   rsp_type          mem_ff [RSPQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [QC_W-1:0]  cnt_ff;
   logic             do_push, do_pop;

   assign wr_full = (cnt_ff == QC_W'(RSPQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_word = mem_ff[rd_ff];
   assign do_push = wr_en && !wr_full;
   assign do_pop  = pop && !empty;

   // Result queue that decouples the scheduler from the consumer.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ff] <= wr_word;
            wr_ff <= (wr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_ff + QC_W'(do_push) - QC_W'(do_pop);
      end
   end

endmodule

// ----- design/dbs_sched.sv -----
module dbs_sched (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [6:0]       csr_wdata,
   input  logic             cmd_valid,
   input  dbs_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_push,
   output dbs_pkg::rsp_type rsp_word,
   input  logic             rsp_full
);
   import dbs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_COUNT,
      ST_END
   } state_type;

   state_type            state_ff;
   slot_type             slot_ff [MAX_OPS];
   logic [CNT_W-1:0]     count_ff, idx_ff, keep_ff;
   logic [NRES_W-1:0]    ncomp_ff;
   slot_type             cur_ff;
   rsp_type              held_ff;
   logic                 held_v_ff;
   logic [NUM_BANKS-1:0] busy_ff, known_ff, clr_ff;
   logic [ROW_BITS-1:0]  open_ff [NUM_BANKS];
   logic [TM_W-1:0]      cas_ff, rcd_ff, rp_ff;
   logic [BW_W-1:0]      bw_ff;
   logic [SIZE_W-1:0]    dq_ff;
   logic [BW_W-1:0]      rem_ff, div_ff;
   logic [3:0]           step_ff;

   slot_type             rd_slot;
   logic                 rd_hit, start_ok;
   logic [TIME_W-1:0]    cyc_nx;
   logic                 done, stall;
   logic [BW_W:0]        trial;
   logic                 trial_ge;
   logic [TIME_W:0]      t_sum;
   logic [TIME_W-1:0]    t_sat;
   logic [CNT_W-1:0]     idx_nx;
   rsp_type              req_rsp;
   slot_type             load_slot, run_slot, keep_slot;

   // Slot under inspection and its start condition.
   always_comb begin
      rd_slot  = slot_ff[idx_ff[SLOT_W-1:0]];
      rd_hit   = known_ff[rd_slot.bank] && (open_ff[rd_slot.bank] == rd_slot.row);
      start_ok = !rd_slot.accessing && !busy_ff[rd_slot.bank];
   end

   // Cycle count and completion test for the current operation.
   always_comb begin
      cyc_nx = cur_ff.cycles;
      if (cur_ff.accessing && (cur_ff.cycles < TIME_MAX)) begin
         cyc_nx = cur_ff.cycles + TIME_W'(1);
      end
      done  = cur_ff.accessing && (cyc_nx >= cur_ff.access_time)
              && (ncomp_ff < NRES_W'(MAX_RESULTS));
      stall = done && held_v_ff && rsp_full;
   end

   // One step of the restoring divider, and the access time.
   always_comb begin
      trial    = {rem_ff, dq_ff[SIZE_W-1]};
      trial_ge = (trial >= {1'b0, div_ff});
      t_sum    = (TIME_W+1)'(cas_ff) + (TIME_W+1)'(dq_ff);
      if (!cur_ff.hit) begin
         t_sum = t_sum + (TIME_W+1)'(rcd_ff) + (TIME_W+1)'(rp_ff);
      end
      t_sat  = (t_sum > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX : t_sum[TIME_W-1:0];
      idx_nx = idx_ff + CNT_W'(1);
   end

   // Slot images for loading, starting and writing back.
   always_comb begin
      load_slot = rd_slot;
      if (start_ok) begin
         load_slot.hit = rd_hit;
      end
      run_slot             = cur_ff;
      run_slot.accessing   = 1'b1;
      run_slot.cycles      = '0;
      run_slot.access_time = t_sat;
      keep_slot            = cur_ff;
      keep_slot.cycles     = cyc_nx;
   end

   // Answer to a new request.
   always_comb begin
      req_rsp.kind     = (count_ff == CNT_W'(MAX_OPS)) ? KIND_REJECT : KIND_ACCEPT;
      req_rsp.tag      = 8'(cmd.tag);
      req_rsp.is_write = cmd.is_write;
      req_rsp.hit      = 1'b0;
      req_rsp.latency  = '0;
      req_rsp.last     = 1'b1;
   end

   // Result push and command pop.
   always_comb begin
      rsp_push = 1'b0;
      rsp_word = req_rsp;
      cmd_pop  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !cmd.is_tick && !rsp_full) begin
               rsp_push = 1'b1;
               cmd_pop  = 1'b1;
            end
         end
         ST_COUNT: begin
            rsp_word = held_ff;
            rsp_push = done && held_v_ff && !rsp_full;
         end
         ST_END: begin
            if (held_v_ff) begin
               rsp_word      = held_ff;
               rsp_word.last = 1'b1;
            end else begin
               rsp_word      = '0;
               rsp_word.kind = KIND_IDLE;
               rsp_word.last = 1'b1;
            end
            rsp_push = !rsp_full;
            cmd_pop  = !rsp_full;
         end
         default: begin
         end
      endcase
   end

   // Sequencer, slot store and bank state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         keep_ff   <= '0;
         ncomp_ff  <= '0;
         held_v_ff <= 1'b0;
         busy_ff   <= '0;
         known_ff  <= '0;
         clr_ff    <= '0;
         cas_ff    <= TM_W'(2);
         rcd_ff    <= TM_W'(2);
         rp_ff     <= TM_W'(2);
         bw_ff     <= BW_W'(8);
         step_ff   <= '0;
      end else begin
         // Configuration writes.
         if (csr_we) begin
            unique case (csr_index)
               CSR_CAS: cas_ff <= csr_wdata[TM_W-1:0];
               CSR_RCD: rcd_ff <= csr_wdata[TM_W-1:0];
               CSR_RP:  rp_ff  <= csr_wdata[TM_W-1:0];
               CSR_BW:  bw_ff  <= csr_wdata[BW_W-1:0];
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            // Take a request into the queue tail, or open a tick pass.
            ST_IDLE: begin
               if (cmd_valid && !cmd.is_tick && !rsp_full) begin
                  if (count_ff != CNT_W'(MAX_OPS)) begin
                     slot_ff[count_ff[SLOT_W-1:0]] <= '{
                        accessing:   1'b0,
                        is_write:    cmd.is_write,
                        bank:        cmd.bank,
                        row:         cmd.row,
                        size:        cmd.size,
                        tag:         cmd.tag,
                        cycles:      '0,
                        access_time: '0,
                        hit:         1'b0};
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end else if (cmd_valid && cmd.is_tick) begin
                  idx_ff    <= '0;
                  keep_ff   <= '0;
                  ncomp_ff  <= '0;
                  held_v_ff <= 1'b0;
                  clr_ff    <= '0;
                  state_ff  <= (count_ff == '0) ? ST_END : ST_LOAD;
               end
            end

            // Fetch the slot; an idle operation on a free bank starts.
            ST_LOAD: begin
               cur_ff <= load_slot;
               if (start_ok) begin
                  dq_ff      <= rd_slot.size;
                  rem_ff     <= '0;
                  div_ff     <= (bw_ff == '0) ? BW_W'(1) : bw_ff;
                  step_ff    <= '0;
                  state_ff   <= ST_DIV;
               end else begin
                  state_ff <= ST_COUNT;
               end
            end

            // Size over bandwidth, one quotient bit a cycle, then the timing.
            ST_DIV: begin
               if (step_ff != 4'(SIZE_W)) begin
                  rem_ff  <= trial_ge ? BW_W'(trial - {1'b0, div_ff}) : trial[BW_W-1:0];
                  dq_ff   <= {dq_ff[SIZE_W-2:0], trial_ge};
                  step_ff <= step_ff + 4'd1;
               end else begin
                  cur_ff <= run_slot;
                  busy_ff[cur_ff.bank] <= 1'b1;
                  state_ff <= ST_COUNT;
               end
            end

            // Step the cycle count; complete or write the slot back compacted.
            ST_COUNT: begin
               if (!stall) begin
                  if (done) begin
                     held_ff <= '{
                        kind:     KIND_DONE,
                        tag:      8'(cur_ff.tag),
                        is_write: cur_ff.is_write,
                        hit:      cur_ff.hit,
                        latency:  cur_ff.access_time,
                        last:     1'b0};
                     held_v_ff <= 1'b1;
                     ncomp_ff  <= ncomp_ff + NRES_W'(1);
                     clr_ff[cur_ff.bank]   <= 1'b1;
                     known_ff[cur_ff.bank] <= 1'b1;
                     open_ff[cur_ff.bank]  <= cur_ff.row;
                  end else begin
                     slot_ff[keep_ff[SLOT_W-1:0]] <= keep_slot;
                     keep_ff <= keep_ff + CNT_W'(1);
                  end
                  idx_ff   <= idx_nx;
                  state_ff <= (idx_nx == count_ff) ? ST_END : ST_LOAD;
               end
            end

            // Close the pass: final result, new fill count, freed banks.
            ST_END: begin
               if (!rsp_full) begin
                  count_ff <= keep_ff;
                  busy_ff  <= busy_ff & ~clr_ff;
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- test/tb.sv -----
module tb;
   import dbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One expected result word.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tag;
      logic       is_write;
      logic       hit;
      logic [8:0] latency;
      logic       last;
   } sched_rsp_type;

   // Bank timing predictor and the queue of words it still expects.
   class sched_scoreboard;
      logic [3:0]  cl, rcd, rp;
      logic [6:0]  bw;
      bit          op_valid[MAX_OPS];
      bit          op_active[MAX_OPS];
      bit          op_write[MAX_OPS];
      logic [2:0]  op_bank[MAX_OPS];
      logic [13:0] op_row[MAX_OPS];
      logic [8:0]  op_size[MAX_OPS];
      logic [7:0]  op_tag[MAX_OPS];
      int          op_count[MAX_OPS];
      int          op_time[MAX_OPS];
      bit          op_hit[MAX_OPS];
      bit          bank_busy[NUM_BANKS];
      bit          row_known[NUM_BANKS];
      logic [13:0] open_row[NUM_BANKS];
      sched_rsp_type pending[$];
      int          errors;
      int          completions;
      int          hits;
      int          rejects;

      function void reset_state();
         cl = 4'd2; rcd = 4'd2; rp = 4'd2; bw = 7'd8;
         for (int i = 0; i < MAX_OPS; i++) begin
            op_valid[i] = 1'b0;
            op_active[i] = 1'b0;
         end
         for (int b = 0; b < NUM_BANKS; b++) begin
            bank_busy[b] = 1'b0;
            row_known[b] = 1'b0;
            open_row[b] = 14'd0;
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [6:0] val);
         case (idx)
            CSR_CAS: cl = val[3:0];
            CSR_RCD: rcd = val[3:0];
            CSR_RP:  rp = val[3:0];
            CSR_BW:  bw = val;
            default: ;
         endcase
      endfunction

      function void add(logic [1:0] k, logic [7:0] t, bit w, bit h, int l, bit last);
         sched_rsp_type r;
         r.kind = k; r.tag = t; r.is_write = w; r.hit = h;
         r.latency = l[8:0]; r.last = last;
         pending.push_back(r);
      endfunction

      // Note an accepted input word and predict its results.
      function void note_word(bit tick, bit wr, logic [2:0] bank, logic [13:0] row,
                              logic [8:0] size, logic [7:0] tag);
         int         slot, n, t, j, div;
         bit         done[MAX_OPS];
         sched_rsp_type r;
         if (!tick) begin
            slot = -1;
            for (int i = 0; i < MAX_OPS; i++)
               if (!op_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
               rejects++;
               add(KIND_REJECT, tag, wr, 1'b0, 0, 1'b1);
               return;
            end
            op_valid[slot] = 1'b1; op_active[slot] = 1'b0; op_write[slot] = wr;
            op_bank[slot] = bank; op_row[slot] = row; op_size[slot] = size;
            op_tag[slot] = tag; op_count[slot] = 0; op_time[slot] = 0;
            op_hit[slot] = 1'b0;
            add(KIND_ACCEPT, tag, wr, 1'b0, 0, 1'b1);
            return;
         end
         // Start waiting operations on free banks, oldest first.
         for (int i = 0; i < MAX_OPS; i++) begin
            if (!op_valid[i] || op_active[i] || bank_busy[op_bank[i]]) continue;
            op_hit[i] = row_known[op_bank[i]] && open_row[op_bank[i]] == op_row[i];
            div = (bw == 0) ? 1 : int'(bw);
            t = int'(cl) + int'(op_size[i]) / div;
            if (!op_hit[i]) t += int'(rcd) + int'(rp);
            if (t > 511) t = 511;
            op_time[i] = t; op_count[i] = 0; op_active[i] = 1'b1;
            bank_busy[op_bank[i]] = 1'b1;
         end
         // Step each active count and collect up to eight completions.
         n = 0;
         for (int i = 0; i < MAX_OPS; i++) begin
            done[i] = 1'b0;
            if (!op_valid[i] || !op_active[i]) continue;
            if (op_count[i] < 511) op_count[i]++;
            if (op_count[i] >= op_time[i] && n < MAX_RESULTS) begin
               add(KIND_DONE, op_tag[i], op_write[i], op_hit[i], op_time[i], 1'b0);
               n++; completions++;
               if (op_hit[i]) hits++;
               bank_busy[op_bank[i]] = 1'b0;
               row_known[op_bank[i]] = 1'b1;
               open_row[op_bank[i]] = op_row[i];
               done[i] = 1'b1;
            end
         end
         // Compact the slot queue, keeping age order.
         j = 0;
         for (int i = 0; i < MAX_OPS; i++) begin
            if (op_valid[i] && !done[i]) begin
               op_valid[j] = 1'b1; op_active[j] = op_active[i]; op_write[j] = op_write[i];
               op_bank[j] = op_bank[i]; op_row[j] = op_row[i]; op_size[j] = op_size[i];
               op_tag[j] = op_tag[i]; op_count[j] = op_count[i];
               op_time[j] = op_time[i]; op_hit[j] = op_hit[i];
               j++;
            end
         end
         for (; j < MAX_OPS; j++) begin
            op_valid[j] = 1'b0; op_active[j] = 1'b0;
         end
         if (n == 0) add(KIND_IDLE, 8'd0, 1'b0, 1'b0, 0, 1'b1);
         else begin
            r = pending.pop_back();
            r.last = 1'b1;
            pending.push_back(r);
         end
      endfunction

      // Compare one accepted result word with the oldest expectation.
      function void check_word(sched_rsp_type got);
         sched_rsp_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word %p", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.kind != exp.kind)
            $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
         if (got.tag != exp.tag)
            $display("%0t: done_tag expected %0d actual %0d", $time, exp.tag, got.tag);
         if (got.is_write != exp.is_write)
            $display("%0t: done_is_write expected %0d actual %0d", $time,
                     exp.is_write, got.is_write);
         if (got.hit != exp.hit)
            $display("%0t: row_hit expected %0d actual %0d", $time, exp.hit, got.hit);
         if (got.latency != exp.latency)
            $display("%0t: latency expected %0d actual %0d", $time,
                     exp.latency, got.latency);
         if (got.last != exp.last)
            $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
         if (got != exp) errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [6:0]  csr_wdata = 0;
   logic        push = 0;
   logic        full;
   logic        req_type = 0;
   logic        req_is_write = 0;
   logic [2:0]  req_bank_index = 0;
   logic [13:0] req_row_index = 0;
   logic [8:0]  req_size_bytes = 0;
   logic [7:0]  req_tag = 0;
   logic        empty;
   logic        pop = 0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_done_tag;
   logic        rsp_done_is_write;
   logic        rsp_row_hit;
   logic [8:0]  rsp_latency;
   logic        rsp_last;

   sched_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  rx_enable = 0;
   int  words_sent = 0;
   logic [7:0] tag_seq = 0;

   localparam int WATCHDOG = 20000;

   dram_bank_open_page_scheduler dut (.*);

   // Clock, 10 ns period.
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Random gap length: mostly short, sometimes long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sample accepted input and result words at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            sb.note_word(req_type, req_is_write, req_bank_index, req_row_index,
                         req_size_bytes, req_tag);
            words_sent++;
         end
         if (pop && !empty)
            sb.check_word({rsp_kind, rsp_done_tag, rsp_done_is_write, rsp_row_hit,
                           rsp_latency, rsp_last});
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Result side: pop with random stalls.
   always begin
      int g;
      @(negedge clock);
      if (!rx_enable) pop <= 0;
      else if (pop && !empty) begin
         g = gap_len();
         if (g > 0) begin
            pop <= 0;
            repeat (g) @(negedge clock);
         end
         pop <= 1;
      end else pop <= 1;
   end

   // Send one word and wait until it is accepted.
   task automatic send_word(bit tick, bit wr, logic [2:0] bank, logic [13:0] row,
                            logic [8:0] size, logic [7:0] tag);
      int g;
      g = gap_len();
      repeat (g) @(negedge clock);
      push = 1'b1;
      req_type <= tick; req_is_write <= wr; req_bank_index <= bank;
      req_row_index <= row; req_size_bytes <= size; req_tag <= tag;
      do @(posedge clock); while (full);
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic request(bit wr, logic [2:0] bank, logic [13:0] row, logic [8:0] size);
      send_word(1'b0, wr, bank, row, size, tag_seq);
      tag_seq++;
   endtask

   task automatic tick();
      send_word(1'b1, 1'($urandom_range(0, 1)), 3'($urandom), 14'($urandom),
                9'($urandom), 8'($urandom));
   endtask

   // Wait for all expected words, then for the longest tick to drain.
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [6:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
   endtask

   task automatic set_timing(int c, int d, int p, int b);
      write_csr(CSR_CAS, 7'(c));
      write_csr(CSR_RCD, 7'(d));
      write_csr(CSR_RP, 7'(p));
      write_csr(CSR_BW, 7'(b));
   endtask

   // Random phase: request bursts on a few rows, interleaved with ticks.
   task automatic random_phase(int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 45)
            request(1'($urandom_range(0, 1)), 3'($urandom),
                    ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 2)),
                    ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 64)));
         else tick();
      end
   endtask

   initial begin
      sb.reset_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      rx_enable = 1;

      // Directed: reset timing, conflict on unknown row, then a row hit.
      request(1'b0, 3'd0, 14'd0, 9'd1);
      request(1'b1, 3'd7, 14'h3fff, 9'd256);
      repeat (12) tick();
      request(1'b0, 3'd0, 14'd0, 9'd8);
      repeat (6) tick();
      drain();

      // Extremes: shortest access (zero size, no row delays) and saturated access time.
      set_timing(1, 0, 0, 64);
      request(1'b1, 3'd1, 14'd5, 9'd0);
      request(1'b0, 3'd1, 14'd5, 9'd1);
      repeat (4) tick();
      drain();
      set_timing(15, 15, 15, 0);
      request(1'b0, 3'd2, 14'd9, 9'd511);
      request(1'b1, 3'd3, 14'd9, 9'd256);
      drain();

      // Fill the queue past full to force rejections, then ticks so that
      // eight operations, one per bank, complete together.
      set_timing(1, 0, 0, 64);
      for (int i = 0; i < 18; i++) request(i[0], i[2:0], 14'd1, 9'd1);
      repeat (6) tick();
      drain();

      // Random phases under several timing settings.
      set_timing(2, 2, 2, 8);
      random_phase(22);
      drain();
      set_timing($urandom_range(1, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(1, 64));
      random_phase(22);
      while (sb.pending.size() != 0) @(negedge clock);
      random_phase(22);
      for (int i = 0; i < 15; i++) tick();
      drain();

      $display("Sent %0d words: %0d completions, %0d row hits, %0d rejects.",
               words_sent, sb.completions, sb.hits, sb.rejects);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ----- dram_bank_open_page_scheduler.f -----
design/dbs_pkg.sv
design/dbs_front.sv
design/dbs_rsp_queue.sv
design/dbs_sched.sv
design/dram_bank_open_page_scheduler.sv
test/tb.sv
